/* sv/pump_tach_stall_monitor_top_macros.svh */
// assertion macros for the pump tachometer stall monitor
`ifndef PUMP_TACH_STALL_MONITOR_TOP_MACROS_SVH
`define PUMP_TACH_STALL_MONITOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PTSM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptsm same-cycle check failed");
`define PTSM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptsm next-cycle check failed");
`else
`define PTSM_ASSERT_SAME(label, ante, cons)
`define PTSM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* sv/ptsm_pkg.sv */
// package with shared constants for the pump tachometer stall monitor
`timescale 1ns / 1ps
`default_nettype none

package ptsm_pkg;

   localparam int unsigned MIN_EDGES_BITS = 16;
   localparam int unsigned TOTAL_BITS = 16;
   localparam logic [MIN_EDGES_BITS-1:0] MIN_EDGES_RESET = 16'd10;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = 16'hffff;

endpackage

`default_nettype wire

/* sv/ptsm_if.sv */
// request and response channel interfaces for the pump tachometer stall monitor
`timescale 1ns / 1ps
`default_nettype none

interface ptsm_req_if;
   logic valid;
   logic ready;
   logic pump_on;
   logic feedback_level;
   logic window_end;
   logic acknowledge;

   modport source (output valid, pump_on, feedback_level, window_end, acknowledge,
                   input ready);
   modport sink (input valid, pump_on, feedback_level, window_end, acknowledge,
                 output ready);
endinterface

interface ptsm_rsp_if;
   import ptsm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  running;
   logic                  fault;
   logic                  blanking;
   logic [TOTAL_BITS-1:0] error_total;
   logic                  change_reported;
   logic                  change_pending;

   modport source (output valid, running, fault, blanking, error_total, change_reported,
                   change_pending, input ready);
   modport sink (input valid, running, fault, blanking, error_total, change_reported,
                 change_pending, output ready);
endinterface

`default_nettype wire

/* sv/pump_tach_stall_monitor_top.sv */
// top level of the pump tachometer stall monitor
// usage:
//   req_ch carries one word per sample: commanded pump state, feedback level,
//   window-end flag and acknowledge flag; rsp_ch returns one status word per
//   request word (running, fault, blanking, error total, change flags)
//   csr_wr_en / csr_wr_data write min_edges, the fewest feedback toggles per
//   window that count as running; write it only while the block is idle
//   latency: the status word appears one cycle after the request word is taken
//   throughput: one word per cycle; the whole update is one pass of logic
//   from the state registers into the status register
//   a stalled rsp_ch keeps its word; req_ch stays ready while the status
//   register is empty or being drained in the same cycle
//   reset (synchronous, active high) clears all monitor state, sets min_edges
//   to 10 and empties the status register
`timescale 1ns / 1ps
`default_nettype none
`include "pump_tach_stall_monitor_top_macros.svh"

module pump_tach_stall_monitor_top #(
   parameter int unsigned WINDOWS    = 4,
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   ptsm_req_if.sink                                  req_ch,
   ptsm_rsp_if.source                                rsp_ch,
   input  wire logic                                 csr_wr_en,
   input  wire logic [ptsm_pkg::MIN_EDGES_BITS-1:0] csr_wr_data
);
   import ptsm_pkg::*;

   localparam int unsigned RING_BITS  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
   localparam int unsigned BLANK_BITS = $clog2(WINDOWS + 1);
   localparam int unsigned CMP_BITS   =
      (COUNT_BITS > MIN_EDGES_BITS) ? COUNT_BITS : MIN_EDGES_BITS;
   localparam logic [RING_BITS-1:0]  RING_LAST = RING_BITS'(WINDOWS - 1);
   localparam logic [BLANK_BITS-1:0] BLANK_MAX = BLANK_BITS'(WINDOWS);

   // configuration
   logic [MIN_EDGES_BITS-1:0] min_edges_ff;

   // monitor state
   logic                  on_ff, on_in;
   logic                  rep_on_ff, rep_on_in;
   logic                  prev_fb_ff, prev_fb_in;
   logic [COUNT_BITS-1:0] edge_cnt_ff, edge_cnt_in;
   logic [COUNT_BITS-1:0] win_cnt_ff [WINDOWS];
   logic [RING_BITS-1:0]  ring_pos_ff, ring_pos_in;
   logic [BLANK_BITS-1:0] blank_cnt_ff, blank_cnt_in;
   logic                  blank_ff, blank_in;
   logic                  fault_ff, fault_in;
   logic                  pend_ff, pend_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;

   // response register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_running_ff, rsp_fault_ff, rsp_blanking_ff;
   logic rsp_reported_ff, rsp_pending_ff;
   logic [TOTAL_BITS-1:0] rsp_total_ff;

   // intermediate values
   logic                  accept;
   logic [BLANK_BITS-1:0] blank_a;
   logic                  fault_a;
   logic [COUNT_BITS-1:0] edge_a;
   logic                  all_below;
   logic                  faulty;
   logic                  changed;
   logic                  reported;
   logic [COUNT_BITS-1:0] cnt_k;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // window compare over the ring with the closing count in place
   always_comb begin
      all_below = 1'b1;
      cnt_k     = '0;
      for (int k = 0; k < WINDOWS; k++) begin
         cnt_k = (req_ch.window_end && ring_pos_ff == RING_BITS'(k)) ? edge_a : win_cnt_ff[k];
         if (CMP_BITS'(cnt_k) >= CMP_BITS'(min_edges_ff)) begin
            all_below = 1'b0;
         end
      end
   end

   always_comb begin
      on_in   = req_ch.pump_on;
      blank_a = (req_ch.pump_on && !on_ff) ? '0 : blank_cnt_ff;
      fault_a = req_ch.pump_on ? fault_ff : 1'b0;

      prev_fb_in = req_ch.feedback_level;
      edge_a     = edge_cnt_ff;
      if (req_ch.feedback_level != prev_fb_ff && edge_cnt_ff != '1) begin
         edge_a = edge_cnt_ff + 1'b1;
      end

      edge_cnt_in  = edge_a;
      ring_pos_in  = ring_pos_ff;
      blank_cnt_in = blank_a;
      blank_in     = blank_ff;
      fault_in     = fault_a;
      pend_in      = pend_ff;
      total_in     = total_ff;
      faulty       = 1'b0;
      changed      = 1'b0;

      if (req_ch.window_end) begin
         edge_cnt_in = '0;
         ring_pos_in = (ring_pos_ff == RING_LAST) ? '0 : ring_pos_ff + 1'b1;
         if (req_ch.pump_on && blank_a < BLANK_MAX) begin
            blank_cnt_in = blank_a + 1'b1;
            blank_in     = 1'b1;
         end else begin
            if (req_ch.pump_on) begin
               faulty = all_below;
            end else begin
               blank_cnt_in = '0;
            end
            blank_in = 1'b0;
            changed  = (rep_on_ff != req_ch.pump_on) || (faulty != fault_a);
            if (faulty && !fault_a && total_ff != TOTAL_MAX) begin
               total_in = total_ff + 1'b1;
            end
            fault_in = faulty;
            pend_in  = pend_ff || changed;
         end
      end

      reported  = 1'b0;
      rep_on_in = rep_on_ff;
      if (req_ch.acknowledge && pend_in && !(req_ch.pump_on && blank_in)) begin
         reported  = 1'b1;
         pend_in   = 1'b0;
         rep_on_in = req_ch.pump_on;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_edges_ff <= MIN_EDGES_RESET;
      end else if (csr_wr_en) begin
         min_edges_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff        <= 1'b0;
         rep_on_ff    <= 1'b0;
         prev_fb_ff   <= 1'b0;
         edge_cnt_ff  <= '0;
         ring_pos_ff  <= '0;
         blank_cnt_ff <= '0;
         blank_ff     <= 1'b0;
         fault_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < WINDOWS; k++) begin
            win_cnt_ff[k] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            on_ff        <= on_in;
            rep_on_ff    <= rep_on_in;
            prev_fb_ff   <= prev_fb_in;
            edge_cnt_ff  <= edge_cnt_in;
            ring_pos_ff  <= ring_pos_in;
            blank_cnt_ff <= blank_cnt_in;
            blank_ff     <= blank_in;
            fault_ff     <= fault_in;
            pend_ff      <= pend_in;
            total_ff     <= total_in;
            if (req_ch.window_end) begin
               win_cnt_ff[ring_pos_ff] <= edge_a;
            end
         end
      end
   end

   // status word
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_running_ff  <= on_in;
         rsp_fault_ff    <= fault_in;
         rsp_blanking_ff <= blank_in && on_in;
         rsp_total_ff    <= total_in;
         rsp_reported_ff <= reported;
         rsp_pending_ff  <= pend_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.running         = rsp_running_ff;
   assign rsp_ch.fault           = rsp_fault_ff;
   assign rsp_ch.blanking        = rsp_blanking_ff;
   assign rsp_ch.error_total     = rsp_total_ff;
   assign rsp_ch.change_reported = rsp_reported_ff;
   assign rsp_ch.change_pending  = rsp_pending_ff;

   `PTSM_ASSERT_SAME(a_fault_needs_on, fault_ff, on_ff)
   `PTSM_ASSERT_SAME(a_blank_cnt_range, 1'b1, blank_cnt_ff <= BLANK_MAX)
   `PTSM_ASSERT_SAME(a_stall_only_when_full, !req_ch.ready, rsp_valid_ff)
   `PTSM_ASSERT_NEXT(a_total_monotonic, accept, total_ff >= $past(total_ff))

endmodule

`default_nettype wire

/* sim/pump_tach_stall_monitor_top_tb.sv */
// self-checking testbench that predicts and checks every status word of the stall monitor
`timescale 1ns / 1ps

module pump_tach_stall_monitor_top_tb;
   import ptsm_pkg::*;

   localparam int unsigned WINDOWS     = 4;
   localparam int unsigned COUNT_BITS  = 16;
   localparam int          CYCLE_LIMIT = 2000000;
   localparam int          PRINT_LIMIT = 40;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic pump_on;
      logic feedback_level;
      logic window_end;
      logic acknowledge;
   } sample_type;

   typedef struct packed {
      logic                  running;
      logic                  fault;
      logic                  blanking;
      logic [TOTAL_BITS-1:0] error_total;
      logic                  change_reported;
      logic                  change_pending;
   } status_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [MIN_EDGES_BITS-1:0] csr_wr_data;

   ptsm_req_if req ();
   ptsm_rsp_if rsp ();

   pump_tach_stall_monitor_top #(
      .WINDOWS    (WINDOWS),
      .COUNT_BITS (COUNT_BITS)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req),
      .rsp_ch      (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // monitor state as predicted
   logic                      on_q;
   logic                      reported_on_q;
   logic                      fb_q;
   logic [COUNT_BITS-1:0]     toggles_q;
   logic [COUNT_BITS-1:0]     window_toggles [WINDOWS];
   logic [1:0]                slot_q;
   logic [2:0]                blank_count_q;
   logic                      blank_q;
   logic                      fault_q;
   logic                      pending_q;
   logic [TOTAL_BITS-1:0]     fault_total_q;
   logic [MIN_EDGES_BITS-1:0] min_edges_q;

   status_type pending_status [$];
   int      error_count;
   int      checked_count;
   int      cycle_count;
   bit      idle_enable;
   int      hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("pump_tach_stall_monitor_top_tb failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("ERROR: %s", msg);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got !== want)
         report_mismatch($sformatf("status word %0d: %s is %0h, expected %0h",
                                   checked_count, name, got, want));
   endtask

   task automatic predict_status(input sample_type s);
      status_type st;
      logic    stalled;
      logic    changed;
      int      k;
      st = '0;
      if (s.pump_on) begin
         if (!on_q)
            blank_count_q = '0;
         on_q = 1'b1;
      end else begin
         on_q = 1'b0;
         fault_q = 1'b0;
      end
      if (s.feedback_level != fb_q) begin
         fb_q = s.feedback_level;
         if (toggles_q != COUNT_MAX)
            toggles_q++;
      end
      if (s.window_end) begin
         window_toggles[slot_q] = toggles_q;
         slot_q++;
         toggles_q = '0;
         if (on_q && blank_count_q < WINDOWS) begin
            blank_count_q++;
            blank_q = 1'b1;
         end else begin
            stalled = 1'b0;
            changed = 1'b0;
            if (on_q) begin
               stalled = 1'b1;
               for (k = 0; k < WINDOWS; k++)
                  if (window_toggles[k] >= min_edges_q)
                     stalled = 1'b0;
            end else begin
               blank_count_q = '0;
            end
            blank_q = 1'b0;
            if (reported_on_q != on_q)
               changed = 1'b1;
            if (stalled != fault_q) begin
               changed = 1'b1;
               if (stalled && fault_total_q != TOTAL_MAX)
                  fault_total_q++;
            end
            fault_q = stalled;
            if (!pending_q)
               pending_q = changed;
         end
      end
      if (s.acknowledge && pending_q && !(on_q && blank_q)) begin
         st.change_reported = 1'b1;
         pending_q = 1'b0;
         reported_on_q = on_q;
      end
      st.running = on_q;
      st.fault = fault_q;
      st.blanking = blank_q && on_q;
      st.error_total = fault_total_q;
      st.change_pending = pending_q;
      pending_status.push_back(st);
   endtask

   always @(posedge clock) begin : score_status
      status_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_status.size() == 0) begin
            report_mismatch($sformatf("status word %0d arrived with none expected",
                                      checked_count));
         end else begin
            want = pending_status.pop_front();
            check_field("running", rsp.running, want.running);
            check_field("fault", rsp.fault, want.fault);
            check_field("blanking", rsp.blanking, want.blanking);
            check_field("error_total", rsp.error_total, want.error_total);
            check_field("change_reported", rsp.change_reported, want.change_reported);
            check_field("change_pending", rsp.change_pending, want.change_pending);
         end
         checked_count++;
      end
   end

   initial begin : drive_ready
      int n;
      rsp.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
            rsp.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (idle_enable && $urandom_range(0, 4) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_word(input sample_type s);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req.valid <= 1'b1;
      {req.pump_on, req.feedback_level, req.window_end, req.acknowledge} <= s;
      do @(posedge clock); while (!req.ready);
      predict_status(s);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (pending_status.size() != 0)
         @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_min_edges(input logic [MIN_EDGES_BITS-1:0] value);
      wait_drained();
      repeat (2) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      min_edges_q = value;
   endtask

   // word order: pump_on, feedback_level, window_end, acknowledge
   task automatic test_startup_blanking();
      send_word(4'b0000);
      send_word(4'b0001);
      send_word(4'b1100);
      send_word(4'b1011);
      send_word(4'b1111);
      send_word(4'b1011);
      send_word(4'b1111);
      send_word(4'b1010);
      send_word(4'b1001);
      send_word(4'b0000);
      send_word(4'b0010);
      send_word(4'b0001);
   endtask

   task automatic test_switch_resets_blanking();
      send_word(4'b1010);
      send_word(4'b1010);
      send_word(4'b0000);
      repeat (4) send_word(4'b1010);
      send_word(4'b1011);
   endtask

   task automatic test_threshold_extremes();
      write_min_edges('0);
      send_word(4'b1010);
      send_word(4'b1001);
      write_min_edges('1);
      send_word(4'b1010);
      send_word(4'b1011);
   endtask

   task automatic test_backpressure();
      int i;
      idle_enable = 1'b0;
      hold_request = 64;
      for (i = 0; i < 30; i++)
         send_word({1'b1, !fb_q, (i % 3 == 2), i[2]});
      wait_drained();
      idle_enable = 1'b1;
   endtask

   task automatic run_segment(input int count);
      sample_type s;
      int      toggle_pct;
      int      win_pct;
      int      ack_pct;
      bit      noise;
      bit      cmd;
      noise = ($urandom_range(0, 99) < 15);
      cmd = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 3))
         0: toggle_pct = 0;
         1: toggle_pct = 5;
         2: toggle_pct = 50;
         default: toggle_pct = 90;
      endcase
      win_pct = $urandom_range(10, 40);
      ack_pct = $urandom_range(5, 50);
      repeat (count) begin
         if (noise) begin
            s = 4'($urandom_range(0, 15));
         end else begin
            s.pump_on = cmd;
            s.feedback_level = ($urandom_range(0, 99) < toggle_pct) ? !fb_q : fb_q;
            s.window_end = ($urandom_range(0, 99) < win_pct);
            s.acknowledge = ($urandom_range(0, 99) < ack_pct);
         end
         send_word(s);
      end
   endtask

   task automatic test_random_traffic();
      int sent;
      int n;
      sent = 0;
      while (sent < 900) begin
         if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
               0: write_min_edges('0);
               1: write_min_edges('1);
               2: write_min_edges(16'($urandom));
               default: write_min_edges(16'($urandom_range(1, 6)));
            endcase
         end
         n = $urandom_range(10, 80);
         run_segment(n);
         sent += n;
      end
   endtask

   task automatic test_long_toggle_run();
      write_min_edges('1);
      repeat (5) send_word({1'b1, fb_q, 1'b1, 1'b0});
      repeat (40) send_word({1'b1, !fb_q, 1'b0, 1'b0});
      send_word({1'b1, !fb_q, 1'b1, 1'b1});
      send_word({1'b1, fb_q, 1'b0, 1'b1});
   endtask

   task automatic test_repeated_faults();
      write_min_edges(16'd1);
      repeat (5) send_word({1'b1, fb_q, 1'b1, 1'b0});
      repeat (10) begin
         send_word({1'b1, !fb_q, 1'b1, 1'($urandom_range(0, 1))});
         repeat (4) send_word({1'b1, fb_q, 1'b1, 1'($urandom_range(0, 1))});
      end
   endtask

   task automatic test_unstalled_traffic();
      write_min_edges(16'($urandom_range(1, 4)));
      repeat (4) run_segment($urandom_range(30, 60));
   endtask

   initial begin : main
      int k;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req.valid <= 1'b0;
      req.pump_on <= 1'b0;
      req.feedback_level <= 1'b0;
      req.window_end <= 1'b0;
      req.acknowledge <= 1'b0;
      on_q = 1'b0;
      reported_on_q = 1'b0;
      fb_q = 1'b0;
      toggles_q = '0;
      for (k = 0; k < WINDOWS; k++)
         window_toggles[k] = '0;
      slot_q = '0;
      blank_count_q = '0;
      blank_q = 1'b0;
      fault_q = 1'b0;
      pending_q = 1'b0;
      fault_total_q = '0;
      min_edges_q = MIN_EDGES_RESET;
      error_count = 0;
      checked_count = 0;
      cycle_count = 0;
      hold_request = 0;
      idle_enable = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_startup_blanking();
      test_switch_resets_blanking();
      test_threshold_extremes();
      test_backpressure();
      test_random_traffic();
      idle_enable = 1'b0;
      test_long_toggle_run();
      test_repeated_faults();
      test_unstalled_traffic();

      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("pump_tach_stall_monitor_top_tb passed");
      else
         $display("pump_tach_stall_monitor_top_tb failed");
      $finish;
   end

endmodule
